// ===== design/cfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the command frame deframer: constants, register map codes,
// configuration and result types. No dependencies.
package cfd_pkg;

  // Command table size and frame framing constants
  localparam int unsigned TABLE_ENTRIES = 4;
  localparam int unsigned HDR_LEN       = 12;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned DIR_WRITE_BIT = 30;
  localparam logic [7:0]  ETX_BYTE      = 8'h03;

  localparam int unsigned IDX_W   = 2;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned ADDR_W  = 5;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BAD_CMD = 2'd0,
    KIND_TOO_BIG = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_READY   = 2'd3
  } kind_e;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_CMD_A       = 3'd0,
    REG_CMD_B       = 3'd1,
    REG_CMD_C       = 3'd2,
    REG_CMD_D       = 3'd3,
    REG_CMD_COUNT   = 3'd4,
    REG_MAX_PAYLOAD = 3'd5
  } reg_idx_e;

  // Configuration seen by the front end
  typedef struct packed {
    logic [TABLE_ENTRIES-1:0][31:0] codes;
    logic [CNT_W-1:0]               count;
    logic [15:0]                    max_payload;
  } cfg_t;

  // One result item; also the queue entry. A data entry with last_byte
  // set expands into two results in the back end.
  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] cmd_index;
    logic [31:0]      cmd_word;
    logic [31:0]      port_index;
    logic [15:0]      req_size;
    logic [7:0]       data_byte;
    logic             last_byte;
  } res_t;

endpackage

// ===== design/cfd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces: input bytes and result items.
// No dependencies.
interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  cmd_index;
  logic [31:0] cmd_word;
  logic [31:0] port_index;
  logic [15:0] req_size;
  logic [7:0]  data_byte;
  logic        last_byte;

  modport source (output valid, output kind, output cmd_index, output cmd_word,
                  output port_index, output req_size, output data_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input kind, input cmd_index, input cmd_word,
                  input port_index, input req_size, input data_byte,
                  input last_byte, output ready);
endinterface

// ===== design/cfd_front.sv =====
`timescale 1ns / 1ps
// Front end: takes stream bytes, assembles the header, matches the command
// and pushes result entries into the queue. Depends on cfd_pkg.
module cfd_front import cfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output res_t       q_data_o
);

  logic             hunt_q, hunt_d;
  logic [3:0]       hdr_cnt_q, hdr_cnt_d;
  logic [31:0]      cmd_q, cmd_d;
  logic [31:0]      port_q, port_d;
  logic [15:0]      size_q, size_d;
  logic             size_hi_q, size_hi_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      pay_cnt_q, pay_cnt_d;

  logic             accept;
  logic [CNT_W-1:0] limit;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic             too_big;
  logic [15:0]      pay_cnt_nxt;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Table match, lowest entry wins
  always_comb begin
    limit   = (cfg_i.count > CNT_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES) : cfg_i.count;
    found   = 1'b0;
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < limit) && (cfg_i.codes[i] == cmd_q)) begin
        found   = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // Size check: last header byte is the top byte of the size word
  assign too_big = size_hi_q || (in_byte_i != 8'h00) || (size_q > cfg_i.max_payload);
  assign pay_cnt_nxt = pay_cnt_q + 16'd1;

  // Frame sequencing and queue entry
  always_comb begin
    hunt_d    = hunt_q;
    hdr_cnt_d = hdr_cnt_q;
    cmd_d     = cmd_q;
    port_d    = port_q;
    size_d    = size_q;
    size_hi_d = size_hi_q;
    idx_d     = idx_q;
    pay_cnt_d = pay_cnt_q;

    q_push_o            = 1'b0;
    q_data_o.kind       = KIND_READY;
    q_data_o.cmd_index  = '0;
    q_data_o.cmd_word   = cmd_q;
    q_data_o.port_index = port_q;
    q_data_o.req_size   = size_q;
    q_data_o.data_byte  = '0;
    q_data_o.last_byte  = 1'b0;

    if (accept) begin
      if (hunt_q) begin
        if (in_byte_i == ETX_BYTE) begin
          hunt_d = 1'b0;
        end
      end else if (hdr_cnt_q < 4'(HDR_LEN)) begin
        hdr_cnt_d = hdr_cnt_q + 4'd1;
        case (hdr_cnt_q[3:2])
          2'd0: cmd_d[8*hdr_cnt_q[1:0] +: 8] = in_byte_i;
          2'd1: port_d[8*hdr_cnt_q[1:0] +: 8] = in_byte_i;
          default: begin
            if (!hdr_cnt_q[1]) begin
              size_d[8*hdr_cnt_q[0] +: 8] = in_byte_i;
            end else if (!hdr_cnt_q[0]) begin
              size_hi_d = (in_byte_i != 8'h00);
            end
          end
        endcase

        // Header complete
        if (hdr_cnt_q == 4'(HDR_LEN - 1)) begin
          if (!found) begin
            q_push_o      = 1'b1;
            q_data_o.kind = KIND_BAD_CMD;
          end else if (too_big) begin
            q_push_o           = 1'b1;
            q_data_o.kind      = KIND_TOO_BIG;
            q_data_o.cmd_index = hit_idx;
          end else if (cmd_q[DIR_WRITE_BIT] && (size_q != 16'd0)) begin
            idx_d     = hit_idx;
            pay_cnt_d = '0;
          end else begin
            q_push_o           = 1'b1;
            q_data_o.kind      = KIND_READY;
            q_data_o.cmd_index = hit_idx;
          end
          if (q_push_o) begin
            hunt_d    = 1'b1;
            hdr_cnt_d = '0;
            idx_d     = '0;
            pay_cnt_d = '0;
          end
        end
      end else begin
        // Payload byte
        q_push_o           = 1'b1;
        q_data_o.kind      = KIND_DATA;
        q_data_o.cmd_index = idx_q;
        q_data_o.data_byte = in_byte_i;
        q_data_o.last_byte = (pay_cnt_nxt >= size_q);
        if (q_data_o.last_byte) begin
          hunt_d    = 1'b1;
          hdr_cnt_d = '0;
          idx_d     = '0;
          pay_cnt_d = '0;
        end else begin
          pay_cnt_d = pay_cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q    <= 1'b0;
      hdr_cnt_q <= '0;
      cmd_q     <= '0;
      port_q    <= '0;
      size_q    <= '0;
      size_hi_q <= 1'b0;
      idx_q     <= '0;
      pay_cnt_q <= '0;
    end else begin
      hunt_q    <= hunt_d;
      hdr_cnt_q <= hdr_cnt_d;
      cmd_q     <= cmd_d;
      port_q    <= port_d;
      size_q    <= size_d;
      size_hi_q <= size_hi_d;
      idx_q     <= idx_d;
      pay_cnt_q <= pay_cnt_d;
    end
  end

endmodule

// ===== design/cfd_fifo.sv =====
`timescale 1ns / 1ps
// Short result queue between front and back end.
// Depends on cfd_pkg (QUEUE_DEPTH, res_t).
module cfd_fifo import cfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output res_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  res_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/cfd_back.sv =====
`timescale 1ns / 1ps
// Back end: drains the queue into the output register, expanding a final
// payload byte into the byte and a command-ready result. Depends on cfd_pkg.
module cfd_back import cfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  res_t q_data_i,
  output logic q_pop_o,
  output logic out_valid_o,
  output res_t out_data_o,
  input  logic out_ready_i
);

  logic out_valid_q;
  res_t out_q;
  logic pend_q;
  logic load;

  assign load        = !out_valid_q || out_ready_i;
  assign q_pop_o     = load && !pend_q && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Control: output valid and pending ready result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        pend_q      <= q_valid_i && q_data_i.last_byte;
      end
    end
  end

  // Output payload; a pending ready reuses the frame fields
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        out_q.kind      <= KIND_READY;
        out_q.data_byte <= '0;
        out_q.last_byte <= 1'b0;
      end else if (q_valid_i) begin
        out_q <= q_data_i;
      end
    end
  end

endmodule

// ===== design/command_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// Command frame deframer top: APB registers, front end, queue, back end.
// The byte that causes a result is registered in the queue and then in the output register.
// Throughput: one byte per cycle; the front end accepts a byte whenever the
// 4-entry queue has room, and the back end emits one result per cycle while the result port is ready.
// Reset (rst_ni, async, low) clears registers, frame state, queue, output.
module command_frame_deframer_top import cfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cfd_byte_if.sink          byte_in_i,
  cfd_res_if.source         res_out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic q_full, q_push, q_pop, q_valid;
  res_t q_wdata, q_rdata;
  logic out_valid;
  res_t out_data;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CMD_A, REG_CMD_B, REG_CMD_C, REG_CMD_D:
          cfg_q.codes[reg_idx[1:0]] <= pwdata;
        REG_CMD_COUNT:   cfg_q.count       <= pwdata[CNT_W-1:0];
        REG_MAX_PAYLOAD: cfg_q.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_CMD_A, REG_CMD_B, REG_CMD_C, REG_CMD_D:
        prdata = cfg_q.codes[reg_idx[1:0]];
      REG_CMD_COUNT:   prdata = {{(32 - CNT_W){1'b0}}, cfg_q.count};
      REG_MAX_PAYLOAD: prdata = {16'h0000, cfg_q.max_payload};
      default:         prdata = '0;
    endcase
  end

  cfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (byte_in_i.valid),
    .in_byte_i  (byte_in_i.in_byte),
    .in_ready_o (byte_in_i.ready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  cfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  cfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (res_out_o.ready)
  );

  // Result port
  assign res_out_o.valid      = out_valid;
  assign res_out_o.kind       = out_data.kind;
  assign res_out_o.cmd_index  = out_data.cmd_index;
  assign res_out_o.cmd_word   = out_data.cmd_word;
  assign res_out_o.port_index = out_data.port_index;
  assign res_out_o.req_size   = out_data.req_size;
  assign res_out_o.data_byte  = out_data.data_byte;
  assign res_out_o.last_byte  = out_data.last_byte;

  // Front end never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("result queue overflow");

  // Final payload byte is followed at once by command ready
  a_ready_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out_o.valid && res_out_o.ready && res_out_o.last_byte) |=>
      (res_out_o.valid && (res_out_o.kind == KIND_READY)))
    else $error("missing command ready after final payload byte");

  // Only payload results carry data
  a_data_only_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out_o.valid && (res_out_o.kind != KIND_DATA)) |->
      ((res_out_o.data_byte == 8'h00) && !res_out_o.last_byte))
    else $error("data on a non-payload result");

endmodule
